### rtl/core/afc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants of the Adler-32 frame checker.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int HEADER_BYTES = 4;
    localparam logic [15:0] ADLER_MOD = 16'd65521;
    localparam logic [30:0] MIN_FRAME_LEN_RESET = 31'd10;
    localparam logic [30:0] MAX_FRAME_LEN_RESET = 31'd67108864;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int NAME_LEN_MIN = 2;

    typedef enum logic [1:0] {
        KIND_NAME_CHAR = 2'd0,
        KIND_NAME_END  = 2'd1,
        KIND_PAYLOAD   = 2'd2,
        KIND_VERDICT   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_LEN  = 2'd1,
        STATUS_BAD_SUM  = 2'd2,
        STATUS_BAD_NAME = 2'd3
    } status_t;

    // Work the back end performs for one queued entry
    typedef enum logic [1:0] {
        OP_SUM         = 2'd0,
        OP_SUM_EMIT    = 2'd1,
        OP_VERDICT_LEN = 2'd2,
        OP_VERDICT_END = 2'd3
    } op_t;

    typedef enum logic {
        REG_MIN_FRAME_LEN = 1'b0,
        REG_MAX_FRAME_LEN = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        op_t         op;
        kind_t       kind;
        logic [7:0]  data;
        logic [31:0] frame_len;
        logic [31:0] name_len;
        logic [31:0] expected;
        logic        name_ok;
    } item_t;

endpackage

### rtl/core/afc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_front
// Frame parser: takes bytes, tracks the frame layout and classifies each byte.
// ----------------------------------------------------------------------------
module afc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [30:0]    cfg_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     rx_byte,
    input  logic           q_full,
    output logic           push,
    output afc_pkg::item_t push_item
);
    import afc_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_BODY,
        PH_DEAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] name_reg, name_next;
    logic [31:0] exp_reg, exp_next;
    logic [30:0] min_reg, max_reg;

    logic        accept;
    logic [31:0] len_shift, name_shift, exp_shift;
    logic        len_bad;
    logic        name_ok;
    logic [32:0] flen_ext, nlen_ext, count_ext, name_lim;
    logic        in_check, last_byte;
    kind_t       body_kind;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign len_shift  = {len_reg[23:0], rx_byte};
    assign name_shift = {name_reg[23:0], rx_byte};
    assign exp_shift  = {exp_reg[23:0], rx_byte};

    assign len_bad = ($signed(len_shift) < $signed({1'b0, min_reg}))
                  || ($signed(len_shift) > $signed({1'b0, max_reg}));

    // Name length must lie in 2 .. frame_len - 8, signed
    assign flen_ext = {len_reg[31], len_reg};
    assign nlen_ext = {name_reg[31], name_reg};
    assign name_ok  = ($signed(name_reg) >= 32'(NAME_LEN_MIN))
                   && ($signed(nlen_ext) <= $signed(flen_ext - 33'(2 * HEADER_BYTES)));

    assign count_ext = {1'b0, count_reg};
    assign in_check  = (count_ext + 33'(HEADER_BYTES)) >= {1'b0, len_reg};
    assign last_byte = (count_ext + 33'd1) == {1'b0, len_reg};
    assign name_lim  = {1'b0, name_reg} + 33'(HEADER_BYTES - 1);

    always_comb
    begin
        if (!name_ok)
        begin
            body_kind = KIND_PAYLOAD;
        end
        else if (count_ext < name_lim)
        begin
            body_kind = KIND_NAME_CHAR;
        end
        else if (count_ext == name_lim)
        begin
            body_kind = KIND_NAME_END;
        end
        else
        begin
            body_kind = KIND_PAYLOAD;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        name_next  = name_reg;
        exp_next   = exp_reg;
        push       = 1'b0;
        push_item.op        = OP_SUM;
        push_item.kind      = body_kind;
        push_item.data      = rx_byte;
        push_item.frame_len = len_reg;
        push_item.name_len  = name_reg;
        push_item.expected  = exp_reg;
        push_item.name_ok   = name_ok;
        case (phase_reg)
            PH_LEN:
            begin
                if (accept)
                begin
                    len_next = len_shift;
                    push_item.frame_len = len_shift;
                    if (count_reg == 32'(HEADER_BYTES - 1))
                    begin
                        count_next = '0;
                        if (len_bad)
                        begin
                            push = 1'b1;
                            push_item.op = OP_VERDICT_LEN;
                            phase_next = PH_DEAD;
                        end
                        else if (len_shift == '0)
                        begin
                            // Empty body: verdict right away, expected word is zero
                            push = 1'b1;
                            push_item.op = OP_VERDICT_END;
                            push_item.expected = '0;
                            len_next = '0;
                            name_next = '0;
                            exp_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 32'd1;
                    end
                end
            end
            PH_BODY:
            begin
                if (accept)
                begin
                    count_next = count_reg + 32'd1;
                    if (in_check)
                    begin
                        exp_next = exp_shift;
                        if (last_byte)
                        begin
                            push = 1'b1;
                            push_item.op = OP_VERDICT_END;
                            push_item.expected = exp_shift;
                            count_next = '0;
                            len_next = '0;
                            name_next = '0;
                            exp_next = '0;
                            phase_next = PH_LEN;
                        end
                    end
                    else if (count_reg < 32'(HEADER_BYTES))
                    begin
                        push = 1'b1;
                        push_item.op = OP_SUM;
                        name_next = name_shift;
                    end
                    else
                    begin
                        push = 1'b1;
                        push_item.op = OP_SUM_EMIT;
                    end
                end
            end
            PH_DEAD:
            begin
                // drop every byte until reset
            end
            default:
            begin
                phase_next = PH_DEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            count_reg <= '0;
            len_reg   <= '0;
            name_reg  <= '0;
            exp_reg   <= '0;
            min_reg   <= MIN_FRAME_LEN_RESET;
            max_reg   <= MAX_FRAME_LEN_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            name_reg  <= name_next;
            exp_reg   <= exp_next;
            if (cfg_we && (cfg_index == REG_MIN_FRAME_LEN))
            begin
                min_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_MAX_FRAME_LEN))
            begin
                max_reg <= cfg_data;
            end
        end
    end

endmodule

### rtl/core/afc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_queue
// Short register queue between the parser and the checksum back end.
// ----------------------------------------------------------------------------
module afc_queue #(
    parameter int DEPTH = afc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  afc_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output afc_pkg::item_t head_item
);
    import afc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = slot_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/afc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_back
// Adler-32 accumulator, verdict logic and output register.
// ----------------------------------------------------------------------------
module afc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  afc_pkg::item_t head_item,
    output logic           pop,
    output logic           dead,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     kind,
    output logic [7:0]     data_byte,
    output logic [1:0]     status,
    output logic [31:0]    frame_len,
    output logic [31:0]    name_len,
    output logic [31:0]    computed_sum
);
    import afc_pkg::*;

    logic [15:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;
    logic        dead_reg, dead_next;
    logic        valid_reg, valid_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    status_t     status_reg, status_next;
    logic [31:0] flen_reg, flen_next;
    logic [31:0] nlen_reg, nlen_next;
    logic [31:0] sum_reg, sum_next;

    logic        emits, can_load, load, work;
    logic [16:0] low_add, high_add;
    logic [15:0] low_mod, high_mod;
    status_t     verdict;

    assign emits    = (head_item.op != OP_SUM);
    assign can_load = !valid_reg || !out_stall;
    assign pop      = head_valid && (dead_reg || !emits || can_load);
    assign work     = pop && !dead_reg;
    assign load     = work && emits;

    assign low_add  = {1'b0, low_reg} + {9'd0, head_item.data};
    assign low_mod  = (low_add >= {1'b0, ADLER_MOD}) ? 16'(low_add - {1'b0, ADLER_MOD})
                                                     : low_add[15:0];
    assign high_add = {1'b0, high_reg} + {1'b0, low_mod};
    assign high_mod = (high_add >= {1'b0, ADLER_MOD}) ? 16'(high_add - {1'b0, ADLER_MOD})
                                                      : high_add[15:0];

    // Checksum mismatch outranks a bad name length
    always_comb
    begin
        if ({high_reg, low_reg} != head_item.expected)
        begin
            verdict = STATUS_BAD_SUM;
        end
        else if (!head_item.name_ok)
        begin
            verdict = STATUS_BAD_NAME;
        end
        else
        begin
            verdict = STATUS_OK;
        end
    end

    always_comb
    begin
        low_next    = low_reg;
        high_next   = high_reg;
        dead_next   = dead_reg;
        valid_next  = load || (valid_reg && out_stall);
        kind_next   = kind_reg;
        data_next   = data_reg;
        status_next = status_reg;
        flen_next   = flen_reg;
        nlen_next   = nlen_reg;
        sum_next    = sum_reg;
        if (load)
        begin
            flen_next = head_item.frame_len;
            nlen_next = head_item.name_len;
        end
        if (work)
        begin
            case (head_item.op)
                OP_SUM:
                begin
                    low_next  = low_mod;
                    high_next = high_mod;
                end
                OP_SUM_EMIT:
                begin
                    low_next    = low_mod;
                    high_next   = high_mod;
                    kind_next   = head_item.kind;
                    data_next   = head_item.data;
                    status_next = STATUS_OK;
                    sum_next    = {high_mod, low_mod};
                end
                OP_VERDICT_LEN:
                begin
                    low_next    = 16'd1;
                    high_next   = '0;
                    dead_next   = 1'b1;
                    kind_next   = KIND_VERDICT;
                    data_next   = '0;
                    status_next = STATUS_BAD_LEN;
                    sum_next    = 32'd1;
                end
                OP_VERDICT_END:
                begin
                    kind_next   = KIND_VERDICT;
                    data_next   = '0;
                    status_next = verdict;
                    sum_next    = {high_reg, low_reg};
                    if (verdict == STATUS_OK)
                    begin
                        low_next  = 16'd1;
                        high_next = '0;
                    end
                    else
                    begin
                        dead_next = 1'b1;
                    end
                end
                default:
                begin
                    dead_next = dead_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= 16'd1;
            high_reg  <= '0;
            dead_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            low_reg   <= low_next;
            high_reg  <= high_next;
            dead_reg  <= dead_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        flen_reg   <= flen_next;
        nlen_reg   <= nlen_next;
        sum_reg    <= sum_next;
    end

    assign dead         = dead_reg;
    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign data_byte    = data_reg;
    assign status       = status_reg;
    assign frame_len    = flen_reg;
    assign name_len     = nlen_reg;
    assign computed_sum = sum_reg;

endmodule

### rtl/core/adler32_frame_checker.sv
`timescale 1ns / 1ps
// Path: a forwarded byte or verdict passes through a queue slot and then the output
//   register, plus any time it waits in the queue while the output is stalled.
// Throughput: one byte per cycle, set by the Adler-32 add and fold in
//   the back end; the input stalls only while the queue is full.
// Reset: rst_n clears parser, queue and accumulator (a=1, b=0) and reloads the
//   length limits to 10 and 67108864.
// ----------------------------------------------------------------------------
// adler32_frame_checker
// Length-prefixed frame checker with Adler-32 body check.
// ----------------------------------------------------------------------------
module adler32_frame_checker #(
    parameter int QUEUE_DEPTH = afc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [1:0]  status,
    output logic [31:0] frame_len,
    output logic [31:0] name_len,
    output logic [31:0] computed_sum
);
    import afc_pkg::*;

    // Front end -> queue: classified bytes and verdict requests
    logic  push;
    item_t push_item;
    logic  q_full;

    // Queue -> back end
    logic  head_valid;
    item_t head_item;
    logic  pop;

    // Back end sticky error flag: set by any failing verdict, held until reset
    logic  dead;

    // Parse length word and body layout; each transfer that produces work
    // for the accumulator enters the queue in the same cycle.
    afc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Decouple the parser from output stalls
    afc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Accumulate Adler-32, decide verdicts, hold the result register.
    // After an error it drains the queue and drops everything.
    afc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .dead         (dead),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .status       (status),
        .frame_len    (frame_len),
        .name_len     (name_len),
        .computed_sum (computed_sum)
    );

    // A failing verdict on the output must have locked the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_VERDICT) && (status != STATUS_OK)) |-> dead)
        else $error("error verdict shown without back end locked");

    // Both Adler-32 halves stay reduced modulo 65521
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((computed_sum[15:0] < ADLER_MOD) && (computed_sum[31:16] < ADLER_MOD)))
        else $error("checksum half not reduced");

    // Forwarded body bytes never carry a verdict status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != KIND_VERDICT)) |-> (status == STATUS_OK))
        else $error("forwarded byte with nonzero status");

    // Once locked, the back end issues no new result
    assert property (@(posedge clk) disable iff (!rst_n)
        (dead && !out_valid) |=> !out_valid)
        else $error("result issued after error lock");

endmodule
